@@ hdl/tile_binning_accumulator_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tile binning accumulator.
// ---------------------------------------------------------------------------
`ifndef TILE_BINNING_ACCUMULATOR_UNIT_MACROS_SVH
`define TILE_BINNING_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/tba_pkg.sv @@
// ---------------------------------------------------------------------------
// tba_pkg
// Types and constants of the tile binning accumulator.
// ---------------------------------------------------------------------------
package tba_pkg;

  localparam int POS_W       = 16;
  localparam int POS_FRAC    = 4;
  localparam int PIX_W       = POS_W - POS_FRAC;
  localparam int VEL_W       = 16;
  localparam int SUM_W       = 32;
  localparam int WEIGHT_W    = 16;
  localparam int TILE_W      = 16;
  localparam int READ_TILE_W = 12;
  localparam int TS_W        = 8;
  localparam int FW_W        = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int MODE_W      = 2;

  // tile = tx + per_row * ty: 12x12 product plus 12-bit term
  localparam int TILE_FULL_W = 2 * PIX_W + 1;

  // iterative divider geometry
  localparam int DIV_N_W   = 12;
  localparam int DIV_D_W   = TS_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 1'd1;

  localparam logic [TS_W-1:0] TILE_SIZE_RESET   = 8'd8;
  localparam logic [FW_W-1:0] FIELD_WIDTH_RESET = 12'd1024;

  localparam logic [MODE_W-1:0] MODE_ACCUM      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ_CLEAR = 2'd2;

  localparam logic [WEIGHT_W-1:0]     WEIGHT_MAX = '1;
  localparam logic signed [SUM_W-1:0] SUM_MAX    = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN    = 32'sh8000_0000;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic [READ_TILE_W-1:0]   read_tile;
  } particle_t;

  typedef struct packed {
    logic [TILE_W-1:0]        tile_number;
    logic                     out_of_range;
    logic [WEIGHT_W-1:0]      tile_weight;
    logic signed [SUM_W-1:0]  sum_vel_x;
    logic signed [SUM_W-1:0]  sum_vel_y;
  } result_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]      weight;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
  } tile_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_READ,
    ST_WB
  } state_t;

endpackage

@@ hdl/tba_ifs.sv @@
// ---------------------------------------------------------------------------
// tba_ifs
// Valid/ready channel interfaces for particles in and tile results out.
// ---------------------------------------------------------------------------
interface tba_particle_if;
  logic                valid;
  logic                ready;
  tba_pkg::particle_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tba_result_if;
  logic              valid;
  logic              ready;
  tba_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tba_divider.sv @@
// ---------------------------------------------------------------------------
// tba_divider
// Restoring divider, one quotient bit per cycle, unsigned 12 by 8 bits.
// ---------------------------------------------------------------------------
module tba_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tba_pkg::DIV_N_W-1:0]   dividend,
  input  logic [tba_pkg::DIV_D_W-1:0]   divisor,
  output logic [tba_pkg::DIV_N_W-1:0]   quotient,
  output logic                          busy
);

  logic [tba_pkg::DIV_CNT_W-1:0] cnt;
  logic [tba_pkg::DIV_D_W-1:0]   rem;
  logic [tba_pkg::DIV_N_W-1:0]   q;
  logic [tba_pkg::DIV_D_W:0]     trial;
  logic                          fits;

  // quotient register shifts the dividend out at the top
  assign trial = {rem, q[tba_pkg::DIV_N_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= tba_pkg::DIV_CNT_W'(tba_pkg::DIV_N_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? tba_pkg::DIV_D_W'(trial - {1'b0, divisor})
                  : trial[tba_pkg::DIV_D_W-1:0];
      q   <= {q[tba_pkg::DIV_N_W-2:0], fits};
    end
  end

  assign quotient = q;
  assign busy     = cnt != '0;

endmodule

@@ hdl/tba_tile_store.sv @@
// ---------------------------------------------------------------------------
// tba_tile_store
// Per-tile count and velocity sums, one write and one registered read port.
// ---------------------------------------------------------------------------
module tba_tile_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  tba_pkg::tile_entry_t  wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output tba_pkg::tile_entry_t  rd_data
);

  tba_pkg::tile_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/tile_binning_accumulator_unit.sv @@
// ---------------------------------------------------------------------------
// tile_binning_accumulator_unit
// Scatter-add of particles into square tiles with saturating totals.
// ---------------------------------------------------------------------------
// Usage:
//   particle channel (valid/ready) takes one item per transfer: mode 0 bins a
//   particle and adds it to its tile, mode 1 reads a tile, mode 2 reads then
//   clears it (mode 3 reads like mode 1). Every item gives one result transfer
//   on the result channel.
//   Accumulate: the three 12-step restoring dividers find tx, ty and tiles per
//   row, then multiply, memory read and write back follow; the result
//   register loads at write back. Read modes: memory read, then write back.
//   One item is in flight at a time, so a tile's read always follows the
//   previous write back and no forwarding is needed.
//   Reset: registers go to tile_size 8, field_width 1024, then a clearing
//   pass zeroes all TILE_COUNT entries, one per cycle; no particle is taken
//   meanwhile, config writes are.
//   Stall: the result register holds a finished result; the block takes the
//   next particle meanwhile and waits in write back only if that one finishes
//   before the earlier result is taken.
//   Config: write tile_size/field_width only while idle.
// ---------------------------------------------------------------------------
`include "tile_binning_accumulator_unit_macros.svh"

module tile_binning_accumulator_unit #(
  parameter int TILE_COUNT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tba_pkg::CFG_W-1:0]        cfg_data,
  tba_particle_if.sink                     particle,
  tba_result_if.source                     result
);

  localparam int AW = $clog2(TILE_COUNT);
  localparam int TFW = tba_pkg::TILE_FULL_W;

  // config registers
  logic [tba_pkg::TS_W-1:0] tile_size;
  logic [tba_pkg::FW_W-1:0] field_width;
  logic [tba_pkg::TS_W-1:0] ts_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size   <= tba_pkg::TILE_SIZE_RESET;
      field_width <= tba_pkg::FIELD_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tba_pkg::REG_TILE_SIZE:   tile_size   <= cfg_data[tba_pkg::TS_W-1:0];
        tba_pkg::REG_FIELD_WIDTH: field_width <= cfg_data[tba_pkg::FW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero tile size acts as one
  assign ts_eff = (tile_size == '0) ? tba_pkg::TS_W'(1) : tile_size;

  // control
  tba_pkg::state_t    state, state_next;
  tba_pkg::particle_t item;
  logic [TFW-1:0]     tile_full;
  logic [AW-1:0]      clr_addr;
  logic               clr_last;
  logic               res_valid;
  tba_pkg::result_t   res_data;

  logic in_ready, accept, div_start, rd_en, wb_fire, clr_we, slot_free;
  logic div_busy, div_busy_y, div_busy_r;
  logic is_accum, is_clear, oor;

  logic [tba_pkg::DIV_N_W-1:0] qx, qy, per_row;
  logic [2*tba_pkg::PIX_W-1:0] prod;

  assign clr_last  = clr_addr == AW'(TILE_COUNT - 1);
  assign slot_free = !res_valid || result.ready;
  assign is_accum  = item.mode == tba_pkg::MODE_ACCUM;
  assign is_clear  = item.mode == tba_pkg::MODE_READ_CLEAR;
  assign oor       = tile_full >= TFW'(TILE_COUNT);

  always_comb begin
    state_next = state;
    case (state)
      tba_pkg::ST_CLEAR: if (clr_last) state_next = tba_pkg::ST_IDLE;
      tba_pkg::ST_IDLE: begin
        if (particle.valid) begin
          state_next = (particle.data.mode == tba_pkg::MODE_ACCUM) ? tba_pkg::ST_DIV
                                                                  : tba_pkg::ST_READ;
        end
      end
      tba_pkg::ST_DIV:  if (!div_busy) state_next = tba_pkg::ST_MUL;
      tba_pkg::ST_MUL:  state_next = tba_pkg::ST_READ;
      tba_pkg::ST_READ: state_next = tba_pkg::ST_WB;
      tba_pkg::ST_WB:   if (slot_free) state_next = tba_pkg::ST_IDLE;
      default:          state_next = tba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == tba_pkg::ST_IDLE;
    accept    = in_ready && particle.valid;
    div_start = accept && (particle.data.mode == tba_pkg::MODE_ACCUM);
    rd_en     = state == tba_pkg::ST_READ;
    wb_fire   = (state == tba_pkg::ST_WB) && slot_free;
    clr_we    = state == tba_pkg::ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tba_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clr_we) clr_addr <= clr_addr + 1'b1;
    end
  end

  // pixel coordinates: floor(pos/16) then floor(./tile); tiles per row: floor(field_width/tile)
  tba_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (particle.data.pos_x[tba_pkg::POS_W-1:tba_pkg::POS_FRAC]),
    .divisor  (ts_eff),
    .quotient (qx),
    .busy     (div_busy)
  );

  tba_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (particle.data.pos_y[tba_pkg::POS_W-1:tba_pkg::POS_FRAC]),
    .divisor  (ts_eff),
    .quotient (qy),
    .busy     (div_busy_y)
  );

  tba_divider u_div_row (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (field_width),
    .divisor  (ts_eff),
    .quotient (per_row),
    .busy     (div_busy_r)
  );

  assign prod = (2*tba_pkg::PIX_W)'(per_row) * (2*tba_pkg::PIX_W)'(qy);

  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= particle.data;
      tile_full <= TFW'(particle.data.read_tile);
    end else if (state == tba_pkg::ST_MUL) begin
      tile_full <= TFW'(qx) + TFW'(prod);
    end
  end

  // tile memory
  tba_pkg::tile_entry_t rd_data, upd, wr_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;

  function automatic logic signed [tba_pkg::SUM_W-1:0] sat_add(
    input logic signed [tba_pkg::SUM_W-1:0] a,
    input logic signed [tba_pkg::VEL_W-1:0] b
  );
    logic signed [tba_pkg::SUM_W:0] s;
    s = (tba_pkg::SUM_W+1)'(a) + (tba_pkg::SUM_W+1)'(b);
    if (s[tba_pkg::SUM_W] != s[tba_pkg::SUM_W-1]) begin
      sat_add = s[tba_pkg::SUM_W] ? tba_pkg::SUM_MIN : tba_pkg::SUM_MAX;
    end else begin
      sat_add = s[tba_pkg::SUM_W-1:0];
    end
  endfunction

  always_comb begin
    upd.weight = (rd_data.weight == tba_pkg::WEIGHT_MAX) ? rd_data.weight
                                                         : rd_data.weight + 1'b1;
    upd.sum_x  = sat_add(rd_data.sum_x, item.vel_x);
    upd.sum_y  = sat_add(rd_data.sum_y, item.vel_y);
  end

  // write back: update on accumulate, zero on read-clear, skip out of range
  assign wr_en   = clr_we || (wb_fire && !oor && (is_accum || is_clear));
  assign wr_addr = clr_we ? clr_addr : tile_full[AW-1:0];
  assign wr_data = (!clr_we && is_accum) ? upd : '0;

  tba_tile_store #(
    .DEPTH (TILE_COUNT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (tile_full[AW-1:0]),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (wb_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      res_data.tile_number  <= (tile_full > TFW'({tba_pkg::TILE_W{1'b1}}))
                               ? {tba_pkg::TILE_W{1'b1}} : tile_full[tba_pkg::TILE_W-1:0];
      res_data.out_of_range <= oor;
      if (oor) begin
        res_data.tile_weight <= '0;
        res_data.sum_vel_x   <= '0;
        res_data.sum_vel_y   <= '0;
      end else if (is_accum) begin
        res_data.tile_weight <= upd.weight;
        res_data.sum_vel_x   <= upd.sum_x;
        res_data.sum_vel_y   <= upd.sum_y;
      end else begin
        res_data.tile_weight <= rd_data.weight;
        res_data.sum_vel_x   <= rd_data.sum_x;
        res_data.sum_vel_y   <= rd_data.sum_y;
      end
    end
  end

  assign particle.ready = in_ready;
  assign result.valid   = res_valid;
  assign result.data    = res_data;

  // checks
  `TBA_ASSERT_IMPLY(a_no_result_in_clear, clk, rst, state == tba_pkg::ST_CLEAR, !result.valid)
  `TBA_ASSERT_IMPLY(a_load_into_free_slot, clk, rst, wb_fire, !res_valid || result.ready)
  `TBA_ASSERT_NEXT(a_one_in_flight, clk, rst, particle.valid && particle.ready, !particle.ready)
  `TBA_ASSERT_IMPLY(a_div_lockstep, clk, rst, div_busy, div_busy_y && div_busy_r && state == tba_pkg::ST_DIV)

endmodule
